// ===== src/mmdp_pkg.sv =====
`default_nettype none

package mmdp_pkg;

   // item kinds carried on req_tuser
   typedef enum logic [1:0] {
      KIND_LOAD_A = 2'd0,
      KIND_LOAD_B = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   // result status carried on rsp_tuser
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_RANGE     = 2'd1,
      STATUS_SATURATED = 2'd2,
      STATUS_RESERVED  = 2'd3
   } status_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_ROWS_A    = 2'd0,
      CSR_INNER_DIM = 2'd1,
      CSR_COLS_B    = 2'd2,
      CSR_NONE      = 2'd3
   } csr_index_type;

   // query sequencer, one-hot
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   localparam int DIM_W     = 5;
   localparam int IDX_W     = 4;
   localparam int ELEM_W    = 32;
   localparam int PROD_W    = 64;
   localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

   // controls from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_ctl_type;

endpackage

`default_nettype wire

// ===== src/matrix_multiply_dot_product.sv =====
`default_nettype none

// Channel   Ports          Width  Contents
// request   req_tdata      40     row, col, value
//           req_tuser      2      kind
// response  rsp_tdata      64     product
//           rsp_tuser      2      status
// config    csr_we/addr    2      register index, write data 5 bits
//
// A load writes its element store in the cycle it is accepted. A query walks
// inner_dim elements through one shared multiply-accumulate, one element per
// cycle. Its sum passes through the memory read, product and accumulate
// registers and then the result register, and a query holds the request side
// until its result is written to the result register. An out-of-range query
// skips the multiply-accumulate and holds the request side only until its
// range result is written. Reset clears control and sets each dimension to
// 16 only: the element stores hold no values until loaded.
// The request side is held off while a query runs or waits for the result
// register to drain; response back-pressure lengthens that wait.
module matrix_multiply_dot_product #(
   parameter int MAX_DIM = 16
) (
   input  wire               clock,
   input  wire               reset,
   // request: [3:0] row, [7:4] col, [39:8] value
   input  wire logic [39:0]  req_tdata,
   // request: [1:0] kind
   input  wire logic [1:0]   req_tuser,
   input  wire               req_tvalid,
   output logic              req_tready,
   // response: [63:0] product
   output logic [63:0]       rsp_tdata,
   // response: [1:0] status
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   input  wire               csr_we,
   input  wire logic [1:0]   csr_addr,
   input  wire logic [4:0]   csr_wdata
);
   import mmdp_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = $clog2(MAX_DIM + 1);
   localparam int ACC_W = PROD_W + KW;
   localparam int CAP   = (MAX_DIM > 31) ? 31 : MAX_DIM;
   localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);

   // configuration
   logic [DIM_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DIM_W-1:0] ra, kd, cb;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_ROWS_A:    rows_a_ff    <= csr_wdata;
            CSR_INNER_DIM: inner_dim_ff <= csr_wdata;
            CSR_COLS_B:    cols_b_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp to the store size
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      logic big;
      big = (32'(d) > MAX_DIM);
      return big ? DIM_W'(CAP) : d;
   endfunction

   assign ra = eff_dim(rows_a_ff);
   assign kd = eff_dim(inner_dim_ff);
   assign cb = eff_dim(cols_b_ff);

   // request fields
   logic [IDX_W-1:0]  req_row, req_col;
   logic [ELEM_W-1:0] req_value;
   kind_type          req_kind;
   logic              req_beat;

   assign req_row   = req_tdata[3:0];
   assign req_col   = req_tdata[7:4];
   assign req_value = req_tdata[39:8];
   assign req_kind  = kind_type'(req_tuser);
   assign req_beat  = req_tvalid & req_tready;

   logic row_in_ra, row_in_kd, col_in_kd, col_in_cb;
   assign row_in_ra = {1'b0, req_row} < ra;
   assign row_in_kd = {1'b0, req_row} < kd;
   assign col_in_kd = {1'b0, req_col} < kd;
   assign col_in_cb = {1'b0, req_col} < cb;

   // sequencer state
   state_type         state_ff, state_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [IDX_W-1:0]  q_row_ff, q_col_ff;
   logic              err_ff, err_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              mul_vld_ff;
   logic              issue, finish, is_query;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [63:0]       rsp_data_ff;
   logic [1:0]        rsp_user_ff;
   logic              pipe_empty;
   logic [63:0]       mac_sum;
   logic              mac_ovf;

   assign req_tready = (state_ff == ST_IDLE);
   assign is_query   = req_beat && (req_kind == KIND_QUERY);
   assign issue      = (state_ff == ST_RUN) && (k_ff < KW'(kd));
   assign pipe_empty = ~rd_vld_ff & ~mul_vld_ff;
   assign finish     = (state_ff == ST_DRAIN) && pipe_empty && (~rsp_vld_ff | rsp_tready);
   assign rd_vld_in  = issue;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      err_in   = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (is_query) begin
               k_in   = '0;
               err_in = ~(row_in_ra & col_in_cb);
               state_in = (row_in_ra & col_in_cb) ? ST_RUN : ST_DRAIN;
            end
         end
         ST_RUN: begin
            if (issue) begin
               k_in = k_ff + KW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= rd_vld_ff;
      end
      k_ff   <= k_in;
      err_ff <= err_in;
      if (is_query) begin
         q_row_ff <= req_row;
         q_col_ff <= req_col;
      end
   end

   // element stores
   logic [ELEM_W-1:0] a_store [DEPTH];
   logic [ELEM_W-1:0] b_store [DEPTH];
   logic [ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic [AW-1:0]     wr_addr, a_raddr, b_raddr;
   logic              a_we, b_we;

   assign wr_addr = AW'(req_row) * DIM_A + AW'(req_col);
   assign a_raddr = AW'(q_row_ff) * DIM_A + AW'(k_ff);
   assign b_raddr = AW'(k_ff) * DIM_A + AW'(q_col_ff);
   assign a_we    = req_beat && (req_kind == KIND_LOAD_A) && row_in_ra && col_in_kd;
   assign b_we    = req_beat && (req_kind == KIND_LOAD_B) && row_in_kd && col_in_cb;

   always_ff @(posedge clock) begin
      if (a_we) begin
         a_store[wr_addr] <= req_value;
      end
      a_rd_ff <= a_store[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_store[wr_addr] <= req_value;
      end
      b_rd_ff <= b_store[b_raddr];
   end

   // shared multiply-accumulate
   mac_ctl_type mac_ctl;
   assign mac_ctl.clear  = is_query;
   assign mac_ctl.mul_en = rd_vld_ff;
   assign mac_ctl.acc_en = mul_vld_ff;

   mmdp_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .a_data (a_rd_ff),
      .b_data (b_rd_ff),
      .sum    (mac_sum),
      .ovf    (mac_ovf)
   );

   // result register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (finish) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      if (finish) begin
         if (err_ff) begin
            rsp_data_ff <= '0;
            rsp_user_ff <= STATUS_RANGE;
         end else begin
            rsp_data_ff <= mac_sum;
            rsp_user_ff <= mac_ovf ? STATUS_SATURATED : STATUS_OK;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== src/mmdp_mac.sv =====
`default_nettype none

// Shared multiply-accumulate: one registered 32x32 signed multiply feeding a
// wide accumulator, plus the 64-bit saturation of the running sum.
module mmdp_mac #(
   parameter int ACC_W = 69
) (
   input  wire                               clock,
   input  wire mmdp_pkg::mac_ctl_type        ctl,
   input  wire logic signed [31:0]           a_data,
   input  wire logic signed [31:0]           b_data,
   output logic signed [63:0]                sum,
   output logic                              ovf
);
   import mmdp_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic                     fits;

   // product stage
   assign prod_in = PROD_W'(a_data * b_data);

   // accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   // sum fits in 64 bits when all bits from 63 up agree
   assign fits = (acc_ff[ACC_W-1:PROD_W-1] == '0) || (acc_ff[ACC_W-1:PROD_W-1] == '1);
   assign ovf  = ~fits;

   always_comb begin
      if (fits) begin
         sum = acc_ff[PROD_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sum = {1'b1, {(PROD_W-1){1'b0}}};
      end else begin
         sum = {1'b0, {(PROD_W-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/mmdp_checker.sv =====
`default_nettype none

// Watches the request, response and register channels, keeps its own copy of
// the element stores and dimensions, and compares every response beat with
// the dot product it predicts.
module mmdp_checker #(
   parameter int MAX_DIM = 16
) (
   input  wire         clock,
   input  wire         reset,
   // request: [3:0] row, [7:4] col, [39:8] value
   input  wire  [39:0] req_tdata,
   // request: [1:0] kind
   input  wire  [1:0]  req_tuser,
   input  wire         req_tvalid,
   input  wire         req_tready,
   // response: [63:0] product
   input  wire  [63:0] rsp_tdata,
   // response: [1:0] status
   input  wire  [1:0]  rsp_tuser,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire         csr_we,
   input  wire  [1:0]  csr_addr,
   input  wire  [4:0]  csr_wdata,
   output int          mismatches,
   output int          outstanding
);

   import mmdp_pkg::*;

   typedef struct packed {
      logic [63:0] product;
      status_type  status;
   } c_elem_type;

   // shadow stores, indexed row * MAX_DIM + col
   logic signed [31:0] a_elems [MAX_DIM*MAX_DIM];
   logic signed [31:0] b_elems [MAX_DIM*MAX_DIM];
   logic [4:0] rows_reg, inner_reg, cols_reg;

   // C elements still owed by the block, oldest first
   c_elem_type c_elements_due [$];

   function automatic int clamp_dim(input logic [4:0] d);
      return (d > MAX_DIM) ? MAX_DIM : int'(d);
   endfunction

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin : observe
      c_elem_type         want;
      kind_type           kind;
      logic [3:0]         row, col;
      logic [31:0]        value;
      logic signed [69:0] sum, fa, fb;
      int                 ra, kd, cb, k;

      if (reset) begin
         rows_reg  = DIM_RESET;
         inner_reg = DIM_RESET;
         cols_reg  = DIM_RESET;
         c_elements_due.delete();
      end else begin
         // register writes; unknown indexes are dropped
         if (csr_we) begin
            case (csr_addr)
               CSR_ROWS_A:    rows_reg  = csr_wdata;
               CSR_INNER_DIM: inner_reg = csr_wdata;
               CSR_COLS_B:    cols_reg  = csr_wdata;
               default: ;
            endcase
         end

         // response beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (c_elements_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response beat: product %h status %0d",
                           rsp_tdata, rsp_tuser);
            end else begin
               want = c_elements_due.pop_front();
               if (rsp_tdata !== want.product || rsp_tuser !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch: expected product %h status %0d, %s %h %s %0d",
                              want.product, want.status, "got product", rsp_tdata,
                              "status", rsp_tuser);
               end
            end
         end

         // request beat: update stores or predict a C element
         if (req_tvalid && req_tready) begin
            kind  = kind_type'(req_tuser);
            row   = req_tdata[3:0];
            col   = req_tdata[7:4];
            value = req_tdata[39:8];
            ra    = clamp_dim(rows_reg);
            kd    = clamp_dim(inner_reg);
            cb    = clamp_dim(cols_reg);
            case (kind)
               KIND_LOAD_A: if (row < ra && col < kd) a_elems[row*MAX_DIM+col] = value;
               KIND_LOAD_B: if (row < kd && col < cb) b_elems[row*MAX_DIM+col] = value;
               KIND_QUERY: begin
                  if (row >= ra || col >= cb) begin
                     want.product = '0;
                     want.status  = STATUS_RANGE;
                  end else begin
                     // exact sum, wide enough for sixteen full-scale products
                     sum = '0;
                     for (k = 0; k < kd; k++) begin
                        fa  = a_elems[row*MAX_DIM+k];
                        fb  = b_elems[k*MAX_DIM+col];
                        sum = sum + fa * fb;
                     end
                     if (sum[69:63] == {7{sum[63]}}) begin
                        want.product = sum[63:0];
                        want.status  = STATUS_OK;
                     end else begin
                        want.product = sum[69] ? 64'h8000_0000_0000_0000
                                               : 64'h7FFF_FFFF_FFFF_FFFF;
                        want.status  = STATUS_SATURATED;
                     end
                  end
                  c_elements_due.push_back(want);
               end
               default: ;
            endcase
         end
      end
      outstanding = c_elements_due.size();
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;

   import mmdp_pkg::*;

   localparam int DIM_MAX     = 16;
   localparam int ITEM_GOAL   = 1600;
   localparam int DRAIN_WAIT  = 40;
   localparam int STALL_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [4:0]  csr_wdata;
   int          mismatches;
   int          outstanding;

   // stimulus bookkeeping: effective dimensions and which entries hold data
   int eff_rows, eff_inner, eff_cols;
   bit a_loaded [DIM_MAX*DIM_MAX];
   bit b_loaded [DIM_MAX*DIM_MAX];
   int beats;
   bit req_pacing, rsp_pacing, steady_end;

   matrix_multiply_dot_product dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   mmdp_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // element values: full-scale extremes, zero, wide random and small fractions
   function automatic logic [31:0] pick_elem();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3, 4, 5: return $urandom();
         default: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      endcase
   endfunction

   // in-range index, or any index when the dimension is zero
   function automatic int pick_index(input int limit);
      return (limit > 0) ? $urandom_range(0, limit - 1) : $urandom_range(0, 15);
   endfunction

   // one request beat; returns at the falling edge after acceptance
   task automatic send_beat(input kind_type kind, input logic [3:0] row,
                            input logic [3:0] col, input logic [31:0] value);
      if (req_pacing && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {value, col, row};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic load_elem(input kind_type kind, input int row, input int col,
                            input logic [31:0] value);
      send_beat(kind, row[3:0], col[3:0], value);
      if (kind == KIND_LOAD_A && row < eff_rows && col < eff_inner) begin
         a_loaded[row*DIM_MAX+col] = 1'b1;
         beats++;
      end
      if (kind == KIND_LOAD_B && row < eff_inner && col < eff_cols) begin
         b_loaded[row*DIM_MAX+col] = 1'b1;
         beats++;
      end
   endtask

   // query C[row][col], first filling any operand entry never written
   task automatic ask_element(input int row, input int col);
      int k;
      if (row < eff_rows && col < eff_cols) begin
         for (k = 0; k < eff_inner; k++) begin
            if (!a_loaded[row*DIM_MAX+k]) load_elem(KIND_LOAD_A, row, k, pick_elem());
            if (!b_loaded[k*DIM_MAX+col]) load_elem(KIND_LOAD_B, k, col, pick_elem());
         end
      end
      send_beat(KIND_QUERY, row[3:0], col[3:0], $urandom());
      beats++;
   endtask

   // stop sending, let every owed result come back, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // write all three dimensions plus one write to the unused index
   task automatic set_dims(input int rows, input int inner, input int cols);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_ROWS_A;
      csr_wdata <= rows[4:0];
      @(negedge clock);
      csr_addr  <= CSR_INNER_DIM;
      csr_wdata <= inner[4:0];
      @(negedge clock);
      csr_addr  <= CSR_COLS_B;
      csr_wdata <= cols[4:0];
      @(negedge clock);
      csr_addr  <= CSR_NONE;
      csr_wdata <= 5'($urandom_range(0, 31));
      @(negedge clock);
      csr_we    <= 1'b0;
      eff_rows  = (rows > DIM_MAX) ? DIM_MAX : rows;
      eff_inner = (inner > DIM_MAX) ? DIM_MAX : inner;
      eff_cols  = (cols > DIM_MAX) ? DIM_MAX : cols;
   endtask

   task automatic random_step();
      int          pick, row, col, k;
      logic [31:0] b_val;
      pick = $urandom_range(0, 19);
      if (pick <= 8) begin
         // refresh part of one A row and one B column, then ask for the product
         row = pick_index(eff_rows);
         col = pick_index(eff_cols);
         for (k = 0; k < eff_inner; k++) begin
            if ($urandom_range(0, 1)) load_elem(KIND_LOAD_A, row, k, pick_elem());
            if ($urandom_range(0, 1)) load_elem(KIND_LOAD_B, k, col, pick_elem());
         end
         ask_element(row, col);
      end else if (pick <= 12) begin
         ask_element(pick_index(eff_rows), pick_index(eff_cols));
      end else if (pick <= 15) begin
         load_elem($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A,
                   $urandom_range(0, 15), $urandom_range(0, 15), pick_elem());
      end else if (pick <= 17) begin
         ask_element($urandom_range(0, 15), $urandom_range(0, 15));
      end else if (pick == 18) begin
         send_beat(KIND_UNUSED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   $urandom());
      end else begin
         // full-scale operands drive the sum toward either rail
         row   = pick_index(eff_rows);
         col   = pick_index(eff_cols);
         b_val = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         for (k = 0; k < eff_inner; k++) begin
            load_elem(KIND_LOAD_A, row, k, 32'h8000_0000);
            load_elem(KIND_LOAD_B, k, col, b_val);
         end
         ask_element(row, col);
      end
   endtask

   task automatic run_phase(input int rows, input int inner, input int cols,
                            input int target);
      settle();
      set_dims(rows, inner, cols);
      req_pacing = !steady_end && ($urandom_range(0, 3) != 0);
      rsp_pacing = !steady_end && ($urandom_range(0, 3) != 0);
      while (beats < target) random_step();
   endtask

   // response back-pressure in random bursts
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_pacing && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: too long without any beat moving
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("matrix_multiply_dot_product verification failed");
      $finish;
   end

   initial begin : stimulus
      int k;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_LOAD_A;
      csr_we     = 1'b0;
      csr_addr   = CSR_ROWS_A;
      csr_wdata  = '0;
      eff_rows   = DIM_MAX;
      eff_inner  = DIM_MAX;
      eff_cols   = DIM_MAX;
      beats      = 0;
      req_pacing = 1'b1;
      rsp_pacing = 1'b1;
      steady_end = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: 2x3 by 3x2, both saturation rails, mixed signs, range errors
      set_dims(2, 3, 2);
      for (k = 0; k < 3; k++) load_elem(KIND_LOAD_A, 0, k, 32'h8000_0000);
      for (k = 0; k < 3; k++) load_elem(KIND_LOAD_B, k, 0, 32'h8000_0000);
      ask_element(0, 0);
      for (k = 0; k < 3; k++) load_elem(KIND_LOAD_B, k, 1, 32'h7FFF_FFFF);
      ask_element(0, 1);
      load_elem(KIND_LOAD_A, 1, 0, 32'h0000_0001);
      load_elem(KIND_LOAD_A, 1, 1, 32'hFFFF_FFFF);
      load_elem(KIND_LOAD_A, 1, 2, 32'h0001_0000);
      ask_element(1, 0);
      ask_element(1, 1);
      ask_element(2, 0);
      ask_element(0, 2);
      ask_element(15, 15);
      // loads outside the dimensions, and the unused kind
      load_elem(KIND_LOAD_A, 2, 0, 32'h1234_5678);
      load_elem(KIND_LOAD_A, 0, 3, 32'h1234_5678);
      load_elem(KIND_LOAD_B, 0, 15, 32'h1234_5678);
      send_beat(KIND_UNUSED, 4'hF, 4'hF, 32'hFFFF_FFFF);

      // fixed settings: full size, minimum, each dimension zero, above maximum
      run_phase(16, 16, 16, 320);
      run_phase(1, 1, 1, 420);
      run_phase(0, 4, 4, 470);
      run_phase(4, 0, 4, 520);
      run_phase(4, 4, 0, 560);
      run_phase(31, 31, 31, 740);
      run_phase(17, 2, 20, 820);
      while (beats < ITEM_GOAL - 200)
         run_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                   beats + 150);
      // closing stretch at full rate on both sides
      steady_end = 1'b1;
      run_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                ITEM_GOAL);
      settle();

      if (mismatches == 0 && outstanding == 0) begin
         $display("matrix_multiply_dot_product verification clean");
      end else begin
         $display("matrix_multiply_dot_product verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
src/mmdp_pkg.sv
src/mmdp_mac.sv
src/matrix_multiply_dot_product.sv
tb/sv/mmdp_checker.sv
tb/sv/tb_top.sv
